[sv/lcsa_pkg.sv]
// ----------------------------------------------------------------------------
// lcsa_pkg
// shared types, constants and the arctangent table of the line fit block
// ----------------------------------------------------------------------------
`default_nettype none

package lcsa_pkg;

  // shared divider geometry
  localparam int unsigned DIV_NUM_W = 26;
  localparam int unsigned DIV_DEN_W = 12;
  localparam int unsigned DIV_CNT_W = 5;

  // cordic geometry
  localparam int unsigned CORDIC_W     = 45;
  localparam int unsigned ANG_Z_W      = 26;
  localparam int unsigned CORDIC_STEPS = 23;
  localparam int unsigned STEP_W       = 5;
  localparam logic signed [CORDIC_W-1:0] NORM_LIMIT = 45'sh100_0000_0000;

  // front to back queue
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = 2;

  localparam logic [13:0] ACC_MAX    = 14'd16383;
  localparam logic [7:0]  CNT_MAX    = 8'd255;
  localparam logic [7:0]  CODE_MAX   = 8'd254;
  localparam logic [7:0]  MASS_EMPTY = 8'd127;
  localparam logic [15:0] ANGLE_CAP  = 16'd23040;

  // register indexes
  localparam logic [2:0] REG_BAND_FIRST_ROW = 3'd0;
  localparam logic [2:0] REG_BAND_ROW_COUNT = 3'd1;
  localparam logic [2:0] REG_MASS_ROW       = 3'd2;
  localparam logic [2:0] REG_MASS_COL_MIN   = 3'd3;
  localparam logic [2:0] REG_MASS_COL_MAX   = 3'd4;
  localparam logic [2:0] REG_ANGLE_CENTER   = 3'd5;
  localparam logic [2:0] REG_ANGLE_GAIN     = 3'd6;

  typedef struct packed {
    logic [6:0]  band_first_row;
    logic [5:0]  band_row_count;
    logic [6:0]  mass_row;
    logic [7:0]  mass_col_min;
    logic [7:0]  mass_col_max;
    logic [7:0]  angle_center;
    logic [15:0] angle_gain;
  } cfg_t;

  typedef struct packed {
    logic        close;
    logic        frame;
    logic [6:0]  row;
    logic [13:0] weight;
    logic [7:0]  count;
    logic [13:0] mass_weight;
    logic [7:0]  mass_count;
  } entry_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_NUM_W-1:0] quot;
  } div_rsp_t;

  typedef struct packed {
    logic                       start;
    logic signed [CORDIC_W-1:0] x;
    logic signed [CORDIC_W-1:0] y;
  } cor_req_t;

  typedef struct packed {
    logic               done;
    logic [ANG_Z_W-1:0] z;
  } cor_rsp_t;

  typedef enum logic [1:0] {
    C_IDLE,
    C_NORM,
    C_ITER
  } cordic_state_e;

  typedef enum logic [3:0] {
    B_IDLE,
    B_ROW_DIV,
    B_ROW_ACC,
    B_MASS,
    B_MASS_DIV1,
    B_MASS_SUB,
    B_MASS_DIV2,
    B_ANG_MUL,
    B_ANG_SUB,
    B_CORDIC,
    B_ANG_MUL2,
    B_ANG_FIN,
    B_OUT
  } back_state_e;

  // atan(2^-i) in degrees, scaled by 65536
  function automatic logic [21:0] atan_entry(input logic [STEP_W-1:0] i);
    logic [21:0] v;
    case (i)
      5'd0:    v = 22'd2949120;
      5'd1:    v = 22'd1740967;
      5'd2:    v = 22'd919879;
      5'd3:    v = 22'd466945;
      5'd4:    v = 22'd234378;
      5'd5:    v = 22'd117304;
      5'd6:    v = 22'd58666;
      5'd7:    v = 22'd29335;
      5'd8:    v = 22'd14668;
      5'd9:    v = 22'd7334;
      5'd10:   v = 22'd3667;
      5'd11:   v = 22'd1833;
      5'd12:   v = 22'd917;
      5'd13:   v = 22'd458;
      5'd14:   v = 22'd229;
      5'd15:   v = 22'd115;
      5'd16:   v = 22'd57;
      5'd17:   v = 22'd29;
      5'd18:   v = 22'd14;
      5'd19:   v = 22'd7;
      5'd20:   v = 22'd4;
      5'd21:   v = 22'd2;
      5'd22:   v = 22'd1;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

[sv/lcsa_front.sv]
// ----------------------------------------------------------------------------
// lcsa_front
// per pixel accumulation of row and mass window sums, emits row close and
// frame end entries
// ----------------------------------------------------------------------------
`default_nettype none

module lcsa_front #(
  parameter int IMAGE_WIDTH   = 160,
  parameter int IMAGE_HEIGHT  = 120,
  parameter int MAX_BAND_ROWS = 32
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire lcsa_pkg::cfg_t cfg_i,
  input  wire logic          accept_i,
  input  wire logic [6:0]    pixel_row_i,
  input  wire logic [7:0]    pixel_col_i,
  input  wire logic          is_dark_i,
  input  wire logic          frame_end_i,
  output logic               push_o,
  output lcsa_pkg::entry_t   entry_o
);

  logic [13:0] rw_q, rw_d, mw_q, mw_d;
  logic [7:0]  rc_q, rc_d, mc_q, mc_d;
  logic        on_raster, in_band, row_add, mass_add, close, row_sample;
  logic [5:0]  eff_rows;
  logic [6:0]  row_off;
  logic [14:0] rw_sum, mw_sum;

  always_comb begin
    on_raster = (32'(pixel_row_i) < IMAGE_HEIGHT) && (32'(pixel_col_i) < IMAGE_WIDTH);
    eff_rows  = (32'(cfg_i.band_row_count) > MAX_BAND_ROWS) ? 6'(MAX_BAND_ROWS)
                                                            : cfg_i.band_row_count;
    row_off   = pixel_row_i - cfg_i.band_first_row;
    in_band   = (pixel_row_i >= cfg_i.band_first_row) && (row_off < {1'b0, eff_rows});
    row_add   = is_dark_i && on_raster && in_band;
    mass_add  = is_dark_i && on_raster && (pixel_row_i == cfg_i.mass_row) &&
                (pixel_col_i >= cfg_i.mass_col_min) && (pixel_col_i <= cfg_i.mass_col_max);
    close     = on_raster && (32'(pixel_col_i) == IMAGE_WIDTH - 1);

    // saturating sums
    rw_sum = {1'b0, rw_q} + {7'd0, pixel_col_i};
    mw_sum = {1'b0, mw_q} + {7'd0, pixel_col_i};
    rw_d   = rw_q;
    rc_d   = rc_q;
    mw_d   = mw_q;
    mc_d   = mc_q;
    if (row_add) begin
      rw_d = (rw_sum > {1'b0, lcsa_pkg::ACC_MAX}) ? lcsa_pkg::ACC_MAX : rw_sum[13:0];
      rc_d = (rc_q == lcsa_pkg::CNT_MAX) ? rc_q : rc_q + 8'd1;
    end
    if (mass_add) begin
      mw_d = (mw_sum > {1'b0, lcsa_pkg::ACC_MAX}) ? lcsa_pkg::ACC_MAX : mw_sum[13:0];
      mc_d = (mc_q == lcsa_pkg::CNT_MAX) ? mc_q : mc_q + 8'd1;
    end

    // only band rows with dark pixels give the back stage work
    row_sample = close && in_band && (rc_d != 8'd0);

    push_o              = accept_i && (row_sample || frame_end_i);
    entry_o.close       = row_sample;
    entry_o.frame       = frame_end_i;
    entry_o.row         = pixel_row_i;
    entry_o.weight      = rw_d;
    entry_o.count       = rc_d;
    entry_o.mass_weight = mw_d;
    entry_o.mass_count  = mc_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rw_q <= '0;
      rc_q <= '0;
      mw_q <= '0;
      mc_q <= '0;
    end else if (accept_i) begin
      if (close || frame_end_i) begin
        rw_q <= '0;
        rc_q <= '0;
      end else begin
        rw_q <= rw_d;
        rc_q <= rc_d;
      end
      if (frame_end_i) begin
        mw_q <= '0;
        mc_q <= '0;
      end else begin
        mw_q <= mw_d;
        mc_q <= mc_d;
      end
    end
  end

endmodule

`default_nettype wire

[sv/lcsa_fifo.sv]
// ----------------------------------------------------------------------------
// lcsa_fifo
// short queue of row close and frame end entries between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module lcsa_fifo (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire lcsa_pkg::entry_t data_i,
  input  wire logic             pop_i,
  output lcsa_pkg::entry_t      data_o,
  output logic                  full_o,
  output logic                  empty_o
);

  lcsa_pkg::entry_t mem_q [lcsa_pkg::QUEUE_DEPTH];
  logic [lcsa_pkg::QPTR_W-1:0] wr_q, rd_q;
  logic [lcsa_pkg::QPTR_W:0]   cnt_q;

  assign full_o  = (cnt_q == (lcsa_pkg::QPTR_W + 1)'(lcsa_pkg::QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i && !full_o) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i && !empty_o) begin
        rd_q <= rd_q + 1'b1;
      end
      if ((push_i && !full_o) && !(pop_i && !empty_o)) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!(push_i && !full_o) && (pop_i && !empty_o)) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

[sv/lcsa_div.sv]
// ----------------------------------------------------------------------------
// lcsa_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module lcsa_div (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire lcsa_pkg::div_req_t req_i,
  output lcsa_pkg::div_rsp_t      rsp_o
);

  localparam int unsigned NW = lcsa_pkg::DIV_NUM_W;
  localparam int unsigned DW = lcsa_pkg::DIV_DEN_W;

  logic [NW-1:0] quo_q;
  logic [DW-1:0] rem_q, den_q;
  logic [lcsa_pkg::DIV_CNT_W-1:0] cnt_q;
  logic          busy_q, done_q;
  logic [DW:0]   trial, diff;
  logic          ge;

  always_comb begin
    trial = {rem_q, quo_q[NW-1]};
    diff  = trial - {1'b0, den_q};
    ge    = trial >= {1'b0, den_q};
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= lcsa_pkg::DIV_CNT_W'(NW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == lcsa_pkg::DIV_CNT_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= req_i.num;
      rem_q <= '0;
      den_q <= req_i.den;
    end else if (busy_q) begin
      quo_q <= {quo_q[NW-2:0], ge};
      rem_q <= ge ? diff[DW-1:0] : trial[DW-1:0];
    end
  end

endmodule

`default_nettype wire

[sv/lcsa_cordic.sv]
// ----------------------------------------------------------------------------
// lcsa_cordic
// vectoring cordic arctangent in degrees, normalize then 23 rotations
// ----------------------------------------------------------------------------
`default_nettype none

module lcsa_cordic (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire lcsa_pkg::cor_req_t req_i,
  output lcsa_pkg::cor_rsp_t      rsp_o
);

  localparam int unsigned W  = lcsa_pkg::CORDIC_W;
  localparam int unsigned ZW = lcsa_pkg::ANG_Z_W;

  lcsa_pkg::cordic_state_e state_q, state_d;
  logic signed [W-1:0]  x_q, y_q, xs, ys;
  logic signed [ZW-1:0] z_q, tab;
  logic [lcsa_pkg::STEP_W-1:0] i_q;
  logic done_q, below_lim;

  always_comb begin
    xs        = x_q >>> i_q;
    ys        = y_q >>> i_q;
    tab       = $signed({4'd0, lcsa_pkg::atan_entry(i_q)});
    below_lim = (x_q < lcsa_pkg::NORM_LIMIT) && (y_q < lcsa_pkg::NORM_LIMIT);
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      lcsa_pkg::C_IDLE: begin
        if (req_i.start) state_d = lcsa_pkg::C_NORM;
      end
      lcsa_pkg::C_NORM: begin
        if (!below_lim) state_d = lcsa_pkg::C_ITER;
      end
      lcsa_pkg::C_ITER: begin
        if (i_q == lcsa_pkg::STEP_W'(lcsa_pkg::CORDIC_STEPS - 1)) state_d = lcsa_pkg::C_IDLE;
      end
      default: state_d = lcsa_pkg::C_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lcsa_pkg::C_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == lcsa_pkg::C_ITER) && (state_d == lcsa_pkg::C_IDLE);
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      lcsa_pkg::C_IDLE: begin
        if (req_i.start) begin
          x_q <= req_i.x;
          y_q <= req_i.y;
          z_q <= '0;
          i_q <= '0;
        end
      end
      lcsa_pkg::C_NORM: begin
        if (below_lim) begin
          x_q <= x_q <<< 1;
          y_q <= y_q <<< 1;
        end
      end
      lcsa_pkg::C_ITER: begin
        if (y_q >= 0) begin
          x_q <= x_q + ys;
          y_q <= y_q - xs;
          z_q <= z_q + tab;
        end else begin
          x_q <= x_q - ys;
          y_q <= y_q + xs;
          z_q <= z_q - tab;
        end
        i_q <= i_q + 1'b1;
      end
      default: ;
    endcase
  end

  assign rsp_o.done = done_q;
  assign rsp_o.z    = (z_q < 0) ? '0 : z_q;

endmodule

`default_nettype wire

[sv/lcsa_back.sv]
// ----------------------------------------------------------------------------
// lcsa_back
// row centroid division, regression sums, mass code and angle code
// ----------------------------------------------------------------------------
`default_nettype none

module lcsa_back #(
  parameter int MAX_BAND_ROWS = 32
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire lcsa_pkg::cfg_t   cfg_i,
  input  wire logic             q_empty_i,
  input  wire lcsa_pkg::entry_t q_data_i,
  output logic                  q_pop_o,
  input  wire logic             pop_i,
  output logic                  out_valid_o,
  output logic [7:0]            mass_code_o,
  output logic [7:0]            angle_code_o,
  output logic [5:0]            sample_rows_o
);

  localparam logic [5:0] SAMPLE_CAP = (MAX_BAND_ROWS > 63) ? 6'd63 : 6'(MAX_BAND_ROWS);

  lcsa_pkg::back_state_e state_q, state_d;
  lcsa_pkg::div_req_t    div_req;
  lcsa_pkg::div_rsp_t    div_rsp;
  lcsa_pkg::cor_req_t    cor_req;
  lcsa_pkg::cor_rsp_t    cor_rsp;

  lcsa_pkg::entry_t ent_q;
  logic [15:0] c_q;
  logic [5:0]  sc_q;
  logic [11:0] srow_q;
  logic [20:0] scen_q;
  logic [18:0] ssq_q;
  logic [27:0] src_q;
  logic [17:0] x_q;
  logic [7:0]  mass_q, ang_q;
  logic [33:0] p1_q;
  logic [32:0] p2_q;
  logic [24:0] p3_q;
  logic [23:0] p4_q;
  logic        neg_q;
  logic signed [15:0] a_q;
  logic signed [32:0] prod_q;
  logic        out_valid_q;

  logic [11:0] lo, span, mx5;
  logic signed [18:0] mdiff;
  logic [17:0] w10;
  logic [15:0] cen_sat;
  logic [13:0] rr;
  logic [22:0] rcp;
  logic signed [34:0] num, nadj, nabs;
  logic signed [25:0] den, dabs;
  logic        nneg;
  logic [17:0] zt;
  logic [15:0] amag;
  logic [32:0] pm;
  logic signed [17:0] qs, asum;
  logic [7:0]  ctr_clamp;

  lcsa_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  lcsa_cordic u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (cor_req),
    .rsp_o  (cor_rsp)
  );

  always_comb begin
    lo      = {4'd0, cfg_i.mass_col_min} * 12'd10;
    span    = ({4'd0, cfg_i.mass_col_max} - {4'd0, cfg_i.mass_col_min}) * 12'd10;
    mx5     = ({4'd0, cfg_i.mass_col_min} + {4'd0, cfg_i.mass_col_max}) * 12'd5;
    mdiff   = $signed({1'b0, x_q}) - $signed({7'd0, lo});
    w10     = {4'd0, ent_q.mass_weight} * 18'd10;
    cen_sat = (div_rsp.quot[25:16] != '0) ? 16'hFFFF : div_rsp.quot[15:0];
    rr      = {7'd0, ent_q.row} * {7'd0, ent_q.row};
    rcp     = {16'd0, ent_q.row} * {7'd0, c_q};
    num     = $signed({1'b0, p1_q}) - $signed({2'b0, p2_q});
    den     = $signed({1'b0, p3_q}) - $signed({2'b0, p4_q});
    dabs    = (den < 0) ? -den : den;
    nadj    = (den < 0) ? -num : num;
    nneg    = nadj < 0;
    nabs    = nneg ? -nadj : nadj;
    zt      = cor_rsp.z[lcsa_pkg::ANG_Z_W-1:8];
    amag    = (zt > {2'd0, lcsa_pkg::ANGLE_CAP}) ? lcsa_pkg::ANGLE_CAP : zt[15:0];
    pm      = (prod_q < 0) ? 33'(-prod_q) : 33'(prod_q);
    qs      = (prod_q < 0) ? -$signed({1'b0, pm[32:16]}) : $signed({1'b0, pm[32:16]});
    asum    = $signed({10'd0, cfg_i.angle_center}) + qs;
    ctr_clamp = (cfg_i.angle_center > lcsa_pkg::CODE_MAX) ? lcsa_pkg::CODE_MAX
                                                         : cfg_i.angle_center;
  end

  // next state and unit requests
  always_comb begin
    state_d       = state_q;
    q_pop_o       = 1'b0;
    div_req.start = 1'b0;
    div_req.num   = lcsa_pkg::DIV_NUM_W'({q_data_i.weight, 8'd0});
    div_req.den   = {4'd0, q_data_i.count};
    cor_req.start = 1'b0;
    cor_req.x     = $signed({11'd0, dabs, 8'd0});
    cor_req.y     = $signed({10'd0, nabs});
    case (state_q)
      lcsa_pkg::B_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          if (q_data_i.close) begin
            div_req.start = 1'b1;
            state_d = lcsa_pkg::B_ROW_DIV;
          end else begin
            state_d = lcsa_pkg::B_MASS;
          end
        end
      end
      lcsa_pkg::B_ROW_DIV: begin
        if (div_rsp.done) state_d = lcsa_pkg::B_ROW_ACC;
      end
      lcsa_pkg::B_ROW_ACC: begin
        state_d = ent_q.frame ? lcsa_pkg::B_MASS : lcsa_pkg::B_IDLE;
      end
      lcsa_pkg::B_MASS: begin
        if (cfg_i.mass_col_max <= cfg_i.mass_col_min) begin
          state_d = lcsa_pkg::B_ANG_MUL;
        end else if (ent_q.mass_count != 8'd0) begin
          div_req.start = 1'b1;
          div_req.num   = lcsa_pkg::DIV_NUM_W'(w10);
          div_req.den   = {4'd0, ent_q.mass_count};
          state_d = lcsa_pkg::B_MASS_DIV1;
        end else begin
          state_d = lcsa_pkg::B_MASS_SUB;
        end
      end
      lcsa_pkg::B_MASS_DIV1: begin
        if (div_rsp.done) state_d = lcsa_pkg::B_MASS_SUB;
      end
      lcsa_pkg::B_MASS_SUB: begin
        if (mdiff < 0) begin
          state_d = lcsa_pkg::B_ANG_MUL;
        end else begin
          div_req.start = 1'b1;
          div_req.num   = lcsa_pkg::DIV_NUM_W'(mdiff[17:0]) * lcsa_pkg::DIV_NUM_W'(254);
          div_req.den   = span;
          state_d = lcsa_pkg::B_MASS_DIV2;
        end
      end
      lcsa_pkg::B_MASS_DIV2: begin
        if (div_rsp.done) state_d = lcsa_pkg::B_ANG_MUL;
      end
      lcsa_pkg::B_ANG_MUL: begin
        state_d = (sc_q < 6'd2) ? lcsa_pkg::B_OUT : lcsa_pkg::B_ANG_SUB;
      end
      lcsa_pkg::B_ANG_SUB: begin
        if (den == 0) begin
          state_d = lcsa_pkg::B_ANG_MUL2;
        end else begin
          cor_req.start = 1'b1;
          state_d = lcsa_pkg::B_CORDIC;
        end
      end
      lcsa_pkg::B_CORDIC: begin
        if (cor_rsp.done) state_d = lcsa_pkg::B_ANG_MUL2;
      end
      lcsa_pkg::B_ANG_MUL2: state_d = lcsa_pkg::B_ANG_FIN;
      lcsa_pkg::B_ANG_FIN:  state_d = lcsa_pkg::B_OUT;
      lcsa_pkg::B_OUT: begin
        if (!out_valid_q) state_d = lcsa_pkg::B_IDLE;
      end
      default: state_d = lcsa_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lcsa_pkg::B_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // regression sums and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sc_q        <= '0;
      srow_q      <= '0;
      scen_q      <= '0;
      ssq_q       <= '0;
      src_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == lcsa_pkg::B_ROW_ACC && sc_q < SAMPLE_CAP) begin
        srow_q <= srow_q + {5'd0, ent_q.row};
        scen_q <= scen_q + {5'd0, c_q};
        ssq_q  <= ssq_q + {5'd0, rr};
        src_q  <= src_q + {5'd0, rcp};
        sc_q   <= sc_q + 6'd1;
      end
      if (state_q == lcsa_pkg::B_OUT && !out_valid_q) begin
        out_valid_q <= 1'b1;
        sc_q        <= '0;
        srow_q      <= '0;
        scen_q      <= '0;
        ssq_q       <= '0;
        src_q       <= '0;
      end else if (pop_i && out_valid_q) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      lcsa_pkg::B_IDLE: begin
        if (!q_empty_i) ent_q <= q_data_i;
      end
      lcsa_pkg::B_ROW_DIV: begin
        if (div_rsp.done) c_q <= cen_sat;
      end
      lcsa_pkg::B_MASS: begin
        if (cfg_i.mass_col_max <= cfg_i.mass_col_min) begin
          mass_q <= lcsa_pkg::MASS_EMPTY;
        end else begin
          x_q <= {6'd0, mx5};
        end
      end
      lcsa_pkg::B_MASS_DIV1: begin
        if (div_rsp.done) x_q <= div_rsp.quot[17:0];
      end
      lcsa_pkg::B_MASS_SUB: begin
        if (mdiff < 0) mass_q <= 8'd0;
      end
      lcsa_pkg::B_MASS_DIV2: begin
        if (div_rsp.done) begin
          mass_q <= (div_rsp.quot > lcsa_pkg::DIV_NUM_W'(lcsa_pkg::CODE_MAX))
                    ? lcsa_pkg::CODE_MAX : div_rsp.quot[7:0];
        end
      end
      lcsa_pkg::B_ANG_MUL: begin
        p1_q <= 34'(sc_q) * 34'(src_q);
        p2_q <= 33'(scen_q) * 33'(srow_q);
        p3_q <= 25'(sc_q) * 25'(ssq_q);
        p4_q <= 24'(srow_q) * 24'(srow_q);
        if (sc_q < 6'd2) ang_q <= ctr_clamp;
      end
      lcsa_pkg::B_ANG_SUB: begin
        neg_q <= nneg;
        if (den == 0) a_q <= '0;
      end
      lcsa_pkg::B_CORDIC: begin
        if (cor_rsp.done) a_q <= neg_q ? -$signed(amag) : $signed(amag);
      end
      lcsa_pkg::B_ANG_MUL2: begin
        prod_q <= a_q * $signed({1'b0, cfg_i.angle_gain});
      end
      lcsa_pkg::B_ANG_FIN: begin
        if (asum < 0) begin
          ang_q <= 8'd0;
        end else if (asum > $signed({10'd0, lcsa_pkg::CODE_MAX})) begin
          ang_q <= lcsa_pkg::CODE_MAX;
        end else begin
          ang_q <= asum[7:0];
        end
      end
      lcsa_pkg::B_OUT: begin
        if (!out_valid_q) begin
          mass_code_o   <= mass_q;
          angle_code_o  <= ang_q;
          sample_rows_o <= sc_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

[sv/line_centroid_slope_angle_core.sv]
// ----------------------------------------------------------------------------
// line_centroid_slope_angle_core
// line angle and center of mass codes from a classified pixel raster
// ----------------------------------------------------------------------------
// usage:
//   pixels enter in raster order on the push/full side, one per cycle while
//   full is low. the front stage sums dark columns per row and in the mass
//   window and queues an entry on every band row close with dark pixels and
//   on frame end.
//   the back stage works entries off: a row close is popped, divided in the
//   shared divider and added to the sums; a frame end takes an optional row
//   close, up to two divisions for the mass code, up to 32 normalize steps
//   and 23 cordic steps for the angle, and multiply stages.
//   the four entry queue fills and full rises only when the back stage
//   falls that far behind.
//   one result per frame appears on the empty/pop side; it is held in an
//   output register until popped, and the back stage waits on it while
//   the front keeps taking pixels until the queue is full.
//   reset puts the registers at their defaults and clears all frame sums.
//   configuration goes over the apb port, register i at byte address 4*i;
//   it must be written only while the block is idle; the block does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module line_centroid_slope_angle_core #(
  parameter int IMAGE_WIDTH   = 160,
  parameter int IMAGE_HEIGHT  = 120,
  parameter int MAX_BAND_ROWS = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  // pixel side
  input  wire logic        push,
  output logic             full,
  input  wire logic [6:0]  pixel_row_i,
  input  wire logic [7:0]  pixel_col_i,
  input  wire logic        is_dark_i,
  input  wire logic        frame_end_i,
  // result side
  output logic             empty,
  input  wire logic        pop,
  output logic [7:0]       mass_code_o,
  output logic [7:0]       angle_code_o,
  output logic [5:0]       sample_rows_o
);

  lcsa_pkg::cfg_t   cfg_q;
  lcsa_pkg::entry_t f_entry, q_entry;
  logic             accept, q_push, q_pop, q_full, q_empty, out_valid, wr_en;

  // apb register file
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.band_first_row <= 7'd40;
      cfg_q.band_row_count <= 6'd16;
      cfg_q.mass_row       <= 7'd60;
      cfg_q.mass_col_min   <= 8'd0;
      cfg_q.mass_col_max   <= 8'd159;
      cfg_q.angle_center   <= 8'd127;
      cfg_q.angle_gain     <= 16'd256;
    end else if (wr_en) begin
      case (paddr[4:2])
        lcsa_pkg::REG_BAND_FIRST_ROW: cfg_q.band_first_row <= pwdata[6:0];
        lcsa_pkg::REG_BAND_ROW_COUNT: cfg_q.band_row_count <= pwdata[5:0];
        lcsa_pkg::REG_MASS_ROW:       cfg_q.mass_row       <= pwdata[6:0];
        lcsa_pkg::REG_MASS_COL_MIN:   cfg_q.mass_col_min   <= pwdata[7:0];
        lcsa_pkg::REG_MASS_COL_MAX:   cfg_q.mass_col_max   <= pwdata[7:0];
        lcsa_pkg::REG_ANGLE_CENTER:   cfg_q.angle_center   <= pwdata[7:0];
        lcsa_pkg::REG_ANGLE_GAIN:     cfg_q.angle_gain     <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      lcsa_pkg::REG_BAND_FIRST_ROW: prdata = {25'd0, cfg_q.band_first_row};
      lcsa_pkg::REG_BAND_ROW_COUNT: prdata = {26'd0, cfg_q.band_row_count};
      lcsa_pkg::REG_MASS_ROW:       prdata = {25'd0, cfg_q.mass_row};
      lcsa_pkg::REG_MASS_COL_MIN:   prdata = {24'd0, cfg_q.mass_col_min};
      lcsa_pkg::REG_MASS_COL_MAX:   prdata = {24'd0, cfg_q.mass_col_max};
      lcsa_pkg::REG_ANGLE_CENTER:   prdata = {24'd0, cfg_q.angle_center};
      lcsa_pkg::REG_ANGLE_GAIN:     prdata = {16'd0, cfg_q.angle_gain};
      default:                      prdata = 32'd0;
    endcase
  end

  // a pixel transfer needs a free queue slot
  assign full   = q_full;
  assign accept = push && !q_full;

  lcsa_front #(
    .IMAGE_WIDTH   (IMAGE_WIDTH),
    .IMAGE_HEIGHT  (IMAGE_HEIGHT),
    .MAX_BAND_ROWS (MAX_BAND_ROWS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .accept_i    (accept),
    .pixel_row_i (pixel_row_i),
    .pixel_col_i (pixel_col_i),
    .is_dark_i   (is_dark_i),
    .frame_end_i (frame_end_i),
    .push_o      (q_push),
    .entry_o     (f_entry)
  );

  // row close / frame end entries
  lcsa_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (f_entry),
    .pop_i   (q_pop),
    .data_o  (q_entry),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  lcsa_back #(
    .MAX_BAND_ROWS (MAX_BAND_ROWS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .q_empty_i     (q_empty),
    .q_data_i      (q_entry),
    .q_pop_o       (q_pop),
    .pop_i         (pop),
    .out_valid_o   (out_valid),
    .mass_code_o   (mass_code_o),
    .angle_code_o  (angle_code_o),
    .sample_rows_o (sample_rows_o)
  );

  // result transfer from the output register
  assign empty = !out_valid;

`ifndef ASSERT_OFF
  // the front never writes into a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_push |-> !q_full)
    else $error("entry pushed into full queue");

  // the back only takes entries that are there
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_pop |-> !q_empty)
    else $error("entry popped from empty queue");

  // a waiting result is not replaced before its transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(angle_code_o) && $stable(mass_code_o)))
    else $error("waiting result changed");
`endif

endmodule

`default_nettype wire

[verif/tb.sv]
// ----------------------------------------------------------------------------
// tb
// self-checking bench for line_centroid_slope_angle_core: sparse pixel
// frames with random content drive the push side, a scoreboard predicts the
// mass code, angle code and sample count of each frame, pop side results
// are checked in order
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

  // scoreboard: own copy of configuration and frame sums, expected codes
  class line_fit_board;
    logic [6:0]  first_row;
    logic [5:0]  row_cnt;
    logic [6:0]  m_row;
    logic [7:0]  m_min;
    logic [7:0]  m_max;
    logic [7:0]  center;
    logic [15:0] gain;
    longint      racc, rcnt, macc, mcnt, nsamp, s_row, s_cen, s_sq, s_rc;
    logic [21:0] frame_codes[$];
    int          errors;
    int          frames;

    function new();
      first_row = 7'd40; row_cnt = 6'd16; m_row = 7'd60;
      m_min = 8'd0; m_max = 8'd159; center = 8'd127; gain = 16'd256;
      errors = 0; frames = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      racc = 0; rcnt = 0; macc = 0; mcnt = 0;
      nsamp = 0; s_row = 0; s_cen = 0; s_sq = 0; s_rc = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] v);
      case (idx)
        lcsa_pkg::REG_BAND_FIRST_ROW: first_row = v[6:0];
        lcsa_pkg::REG_BAND_ROW_COUNT: row_cnt = v[5:0];
        lcsa_pkg::REG_MASS_ROW:       m_row = v[6:0];
        lcsa_pkg::REG_MASS_COL_MIN:   m_min = v[7:0];
        lcsa_pkg::REG_MASS_COL_MAX:   m_max = v[7:0];
        lcsa_pkg::REG_ANGLE_CENTER:   center = v[7:0];
        lcsa_pkg::REG_ANGLE_GAIN:     gain = v[15:0];
        default: ;
      endcase
    endfunction

    function bit band_hit(longint r);
      longint eff;
      eff = (row_cnt > 32) ? 32 : longint'(row_cnt);
      return (r >= first_row) && (r - first_row < eff);
    endfunction

    function longint clamp_code(longint v);
      return (v < 0) ? 0 : ((v > 254) ? 254 : v);
    endfunction

    function void close_row(longint r);
      longint c;
      if (band_hit(r) && rcnt > 0 && nsamp < 32) begin
        c = (racc << 8) / rcnt;
        if (c > 65535) c = 65535;
        s_row = (s_row + r) & 'hFFF;
        s_cen = (s_cen + c) & 'h1FFFFF;
        s_sq  = (s_sq + r * r) & 'h7FFFF;
        s_rc  = (s_rc + r * c) & 'hFFFFFFF;
        nsamp++;
      end
      racc = 0;
      rcnt = 0;
    endfunction

    function longint mass_out();
      longint lo, hi, x;
      if (m_max <= m_min) return 127;
      lo = longint'(m_min) * 10;
      hi = longint'(m_max) * 10;
      if (mcnt > 0) x = (macc * 10) / mcnt;
      else x = (longint'(m_min) + longint'(m_max)) * 5;
      return clamp_code(((x - lo) * 254) / (hi - lo));
    endfunction

    // vectoring rotation, degrees times 65536, x > 0 and y >= 0
    function longint atan_deg(longint x, longint y);
      longint steps[23] = '{2949120, 1740967, 919879, 466945, 234378, 117304, 58666,
                            29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57,
                            29, 14, 7, 4, 2, 1};
      longint z, nx, ny;
      z = 0;
      while (x < (longint'(1) << 40) && y < (longint'(1) << 40)) begin
        x = x * 2;
        y = y * 2;
      end
      for (int i = 0; i < 23; i++) begin
        if (y >= 0) begin
          nx = x + (y >>> i); ny = y - (x >>> i); z = z + steps[i];
        end else begin
          nx = x - (y >>> i); ny = y + (x >>> i); z = z - steps[i];
        end
        x = nx;
        y = ny;
      end
      return (z < 0) ? 0 : z;
    endfunction

    function longint angle_out();
      longint num, den, a;
      bit neg;
      a = 0;
      if (nsamp < 2) return clamp_code(longint'(center));
      num = nsamp * s_rc - s_cen * s_row;
      den = nsamp * s_sq - s_row * s_row;
      if (den != 0) begin
        if (den < 0) begin
          den = -den;
          num = -num;
        end
        neg = num < 0;
        a = atan_deg(den * 256, neg ? -num : num) >> 8;
        if (a > 23040) a = 23040;
        if (neg) a = -a;
      end
      return clamp_code(longint'(center) + (a * longint'(gain)) / 65536);
    endfunction

    function void take_pixel(logic [6:0] r, logic [7:0] c, logic dark, logic fend);
      logic [7:0] m, a;
      if (r < 120 && c < 160) begin
        if (dark && band_hit(r)) begin
          racc = (racc + c > 16383) ? 16383 : racc + c;
          rcnt = (rcnt + 1 > 255) ? 255 : rcnt + 1;
        end
        if (dark && r == m_row && c >= m_min && c <= m_max) begin
          macc = (macc + c > 16383) ? 16383 : macc + c;
          mcnt = (mcnt + 1 > 255) ? 255 : mcnt + 1;
        end
        if (c == 8'd159) close_row(r);
      end
      if (fend) begin
        m = 8'(mass_out());
        a = 8'(angle_out());
        frame_codes.push_back({m, a, nsamp[5:0]});
        clear_frame();
      end
    endfunction

    function void check_frame(logic [7:0] m, logic [7:0] a, logic [5:0] s);
      logic [21:0] want;
      if (frame_codes.size() == 0) begin
        $display("%0t: result with none expected: mass %0d angle %0d rows %0d",
                 $time, m, a, s);
        errors++;
        return;
      end
      want = frame_codes.pop_front();
      frames++;
      if (m !== want[21:14]) begin
        $display("%0t: mass_code expected %0d actual %0d", $time, want[21:14], m);
        errors++;
      end
      if (a !== want[13:6]) begin
        $display("%0t: angle_code expected %0d actual %0d", $time, want[13:6], a);
        errors++;
      end
      if (s !== want[5:0]) begin
        $display("%0t: sample_rows expected %0d actual %0d", $time, want[5:0], s);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        push = 1'b0;
  logic        full;
  logic [6:0]  pixel_row_i = '0;
  logic [7:0]  pixel_col_i = '0;
  logic        is_dark_i = 1'b0;
  logic        frame_end_i = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [7:0]  mass_code_o, angle_code_o;
  logic [5:0]  sample_rows_o;

  line_fit_board board = new();

  bit push_on = 1'b0;   // tracks push so it is never re-driven in one step
  bit calm = 1'b0;      // no idling on either side in the closing phase
  bit hold_req = 1'b0;  // asks the pop side for one long hold-off
  int pixels_sent = 0;

  always #5 clk_i = ~clk_i;

  line_centroid_slope_angle_core dut (.*);

  // pop side: check every transfer, stall in short bursts, one long hold-off
  int stall_left = 0;
  int hold_left = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pop && !empty) board.check_frame(mass_code_o, angle_code_o, sample_rows_o);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = 1500;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        pop <= 1'b0;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(0, 3);
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // one pixel transfer, sometimes with a random gap afterwards
  task automatic send(logic [6:0] r, logic [7:0] c, logic dark, logic fend);
    if (!push_on) push <= 1'b1;
    push_on = 1'b1;
    pixel_row_i <= r;
    pixel_col_i <= c;
    is_dark_i <= dark;
    frame_end_i <= fend;
    do @(posedge clk_i); while (full);
    board.take_pixel(r, c, dark, fend);
    pixels_sent++;
    if (!calm && $urandom_range(0, 5) == 0) begin
      push <= 1'b0;
      push_on = 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  // wait out every expected frame plus the back stage's row work
  task automatic drain();
    if (push_on) push <= 1'b0;
    push_on = 1'b0;
    while (board.frame_codes.size() > 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  task automatic reg_write(logic [2:0] idx, logic [31:0] v);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    board.set_reg(idx, v);
    @(posedge clk_i);
  endtask

  task automatic configure(int phase);
    int unsigned lo;
    case (phase)
      1: begin
        reg_write(lcsa_pkg::REG_BAND_FIRST_ROW, 0);
        reg_write(lcsa_pkg::REG_BAND_ROW_COUNT, 32);
        reg_write(lcsa_pkg::REG_MASS_ROW, 0);
        reg_write(lcsa_pkg::REG_MASS_COL_MIN, 0);
        reg_write(lcsa_pkg::REG_MASS_COL_MAX, 1);
        reg_write(lcsa_pkg::REG_ANGLE_CENTER, 0);
        reg_write(lcsa_pkg::REG_ANGLE_GAIN, 65535);
      end
      2: begin
        // band count above the hardware limit, window at the right edge
        reg_write(lcsa_pkg::REG_BAND_FIRST_ROW, 88);
        reg_write(lcsa_pkg::REG_BAND_ROW_COUNT, 63);
        reg_write(lcsa_pkg::REG_MASS_ROW, 119);
        reg_write(lcsa_pkg::REG_MASS_COL_MIN, 158);
        reg_write(lcsa_pkg::REG_MASS_COL_MAX, 159);
        reg_write(lcsa_pkg::REG_ANGLE_CENTER, 254);
        reg_write(lcsa_pkg::REG_ANGLE_GAIN, 0);
      end
      3: begin
        // empty band and inverted mass window
        reg_write(lcsa_pkg::REG_BAND_FIRST_ROW, 119);
        reg_write(lcsa_pkg::REG_BAND_ROW_COUNT, 0);
        reg_write(lcsa_pkg::REG_MASS_ROW, $urandom_range(0, 119));
        reg_write(lcsa_pkg::REG_MASS_COL_MIN, 100);
        reg_write(lcsa_pkg::REG_MASS_COL_MAX, 50);
        reg_write(lcsa_pkg::REG_ANGLE_CENTER, $urandom_range(0, 254));
        reg_write(lcsa_pkg::REG_ANGLE_GAIN, $urandom_range(0, 65535));
      end
      default: begin
        lo = $urandom_range(0, 150);
        reg_write(lcsa_pkg::REG_BAND_FIRST_ROW, $urandom_range(0, 100));
        reg_write(lcsa_pkg::REG_BAND_ROW_COUNT, $urandom_range(2, 32));
        reg_write(lcsa_pkg::REG_MASS_ROW, $urandom_range(0, 119));
        reg_write(lcsa_pkg::REG_MASS_COL_MIN, lo);
        reg_write(lcsa_pkg::REG_MASS_COL_MAX, $urandom_range(lo + 1, 159));
        reg_write(lcsa_pkg::REG_ANGLE_CENTER, $urandom_range(0, 254));
        reg_write(lcsa_pkg::REG_ANGLE_GAIN, ($urandom_range(0, 1)) ? $urandom_range(0, 1024)
                                                                   : $urandom_range(0, 65535));
      end
    endcase
  endtask

  // a row in or just past the band most of the time, else the mass row or anywhere
  function automatic logic [6:0] pick_row();
    int r;
    if ($urandom_range(0, 3) == 0) return board.m_row;
    if ($urandom_range(0, 7) == 0) return 7'($urandom_range(0, 119));
    r = board.first_row + $urandom_range(0, board.row_cnt + 1);
    return (r > 119) ? 7'($urandom_range(0, 119)) : 7'(r);
  endfunction

  // kinds: 0 sparse rows along a line, 1 many closes (sample limit),
  // 2 one dense row that saturates the sums
  task automatic run_frame(int kind);
    int slope, base, c;
    logic [6:0] r;
    r = pick_row();
    if (kind == 1) begin
      repeat ($urandom_range(30, 40))
        send(pick_row(), 8'd159, $urandom_range(0, 7) != 0, 1'b0);
    end else if (kind == 2) begin
      repeat (262) send(r, 8'($urandom_range(140, 158)), 1'b1, 1'b0);
      send(r, 8'd159, 1'b1, 1'b0);
    end else begin
      slope = $urandom_range(0, 8) - 4;
      base = $urandom_range(20, 140);
      repeat ($urandom_range(0, 6)) begin
        r = pick_row();
        repeat ($urandom_range(1, 4)) begin
          if ($urandom_range(0, 9) == 0) begin
            send(7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)),
                 1'($urandom_range(0, 1)), 1'b0);
          end else begin
            c = base + slope * (int'(r) - int'(board.first_row)) + $urandom_range(0, 10) - 5;
            c = (c < 0) ? 0 : ((c > 158) ? 158 : c);
            send(r, 8'(c), $urandom_range(0, 4) != 0, 1'b0);
          end
        end
        if ($urandom_range(0, 7) != 0) send(r, 8'd159, 1'($urandom_range(0, 1)), 1'b0);
      end
    end
    send(($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 127)) : r,
         8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
  endtask

  initial begin
    int phase_items;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed frames on the default setting (band rows 40..55, mass row 60)
    send(7'd0, 8'd0, 1'b0, 1'b1);                  // empty frame
    send(7'd127, 8'd255, 1'b1, 1'b1);              // off raster, still a result
    send(7'd40, 8'd159, 1'b1, 1'b0);               // same row closed twice: flat
    send(7'd40, 8'd159, 1'b1, 1'b1);
    send(7'd40, 8'd10, 1'b1, 1'b0);                // rising line
    send(7'd40, 8'd159, 1'b0, 1'b0);
    send(7'd41, 8'd100, 1'b1, 1'b0);
    send(7'd41, 8'd159, 1'b0, 1'b0);
    send(7'd60, 8'd0, 1'b1, 1'b0);                 // mass window edges
    send(7'd60, 8'd159, 1'b1, 1'b1);
    send(7'd42, 8'd150, 1'b1, 1'b0);               // falling line
    send(7'd42, 8'd159, 1'b0, 1'b0);
    send(7'd43, 8'd5, 1'b1, 1'b0);
    send(7'd43, 8'd159, 1'b0, 1'b0);
    send(7'd44, 8'd0, 1'b1, 1'b0);
    send(7'd44, 8'd159, 1'b0, 1'b0);
    send(7'd45, 8'd77, 1'b1, 1'b0);                // row left open at frame end
    send(7'd60, 8'd200, 1'b1, 1'b1);
    send(7'd119, 8'd159, 1'b1, 1'b1);              // last raster pixel
    drain();

    for (int phase = 1; phase <= 9; phase++) begin
      if (phase == 9) calm = 1'b1;
      configure(phase);
      if (phase == 4) hold_req = 1'b1;
      if (phase == 5) run_frame(2);
      phase_items = pixels_sent;
      while (pixels_sent - phase_items < 40)
        run_frame(($urandom_range(0, 9) == 0) ? 1 : 0);
      drain();
    end

    $display("tb: %0d pixels over 10 register settings, %0d frame results checked",
             pixels_sent, board.frames);
    if (board.errors == 0 && board.frame_codes.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("tb: timeout");
    $display("tb: done, errors");
    $finish;
  end

endmodule

`default_nettype wire

[files.f]
sv/lcsa_pkg.sv
sv/lcsa_front.sv
sv/lcsa_fifo.sv
sv/lcsa_div.sv
sv/lcsa_cordic.sv
sv/lcsa_back.sv
sv/line_centroid_slope_angle_core.sv
verif/tb.sv
